// ----- rtl/multi_stack_shared_pool_defines.svh -----
// assertion macros for the multi-stack shared pool block
// used by the back end; no other dependencies
`ifndef MULTI_STACK_SHARED_POOL_DEFINES_SVH
`define MULTI_STACK_SHARED_POOL_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MSP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/msp_pkg.sv -----
// shared types and constants for the multi-stack shared pool block
// no dependencies
package msp_pkg;

  // default sizes
  localparam int DEF_NUM_STACKS = 4;
  localparam int DEF_POOL_SLOTS = 64;

  // fixed field widths
  localparam int DATA_W   = 32;
  localparam int SID_W    = 2;
  localparam int STATUS_W = 2;

  // depth of the queue between front and back end (power of two)
  localparam int QUEUE_DEPTH = 2;

  // value returned by a pop from an empty stack
  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = 32'sh7FFF_FFFF;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_e;

  // classified operation handed from front to back end
  typedef struct packed {
    kind_e                     kind;
    logic                      sid_ok;
    logic [SID_W-1:0]          sid;
    logic signed [DATA_W-1:0]  value;
  } op_t;

endpackage

// ----- rtl/msp_front.sv -----
// front end: takes input items, classifies them and queues them for the back end
// depends on msp_pkg
module msp_front #(
  parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [msp_pkg::SID_W-1:0]         stack_id_i,
  input  logic signed [msp_pkg::DATA_W-1:0] push_value_i,
  output logic                              q_valid_o,
  output msp_pkg::op_t                      q_op_o,
  input  logic                              q_deq_i
);
  import msp_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  op_t             entries_q [QUEUE_DEPTH];
  logic [QPW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]  count_q, count_d;
  logic            enq;
  logic            deq;
  op_t             new_op;

  // classify the incoming item
  always_comb begin
    new_op.kind   = kind_e'(kind_i);
    new_op.sid_ok = ({{(32 - SID_W){1'b0}}, stack_id_i} < 32'(NUM_STACKS));
    new_op.sid    = stack_id_i;
    new_op.value  = push_value_i;
  end

  // queue handshake
  assign in_stall_o = (count_q == QCW'(QUEUE_DEPTH));
  assign enq        = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign deq        = q_deq_i && q_valid_o;
  assign q_op_o     = entries_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + QPW'(1) : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + QPW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (enq && !deq) begin
      count_d = count_q + QCW'(1);
    end else if (deq && !enq) begin
      count_d = count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (enq) begin
      entries_q[wr_ptr_q] <= new_op;
    end
  end

endmodule

// ----- rtl/msp_back.sv -----
// back end: runs push and pop against the slot pool, free list and stack tops
// depends on msp_pkg and multi_stack_shared_pool_defines.svh
module msp_back #(
  parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS,
  parameter int POOL_SLOTS = msp_pkg::DEF_POOL_SLOTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  msp_pkg::op_t                        q_op_i,
  output logic                                q_deq_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [msp_pkg::DATA_W-1:0]   pop_value_o,
  output logic [msp_pkg::STATUS_W-1:0]        status_o
);
  import msp_pkg::*;

  // slot pointers carry one extra code: POOL_SLOTS means null
  localparam int PW = $clog2(POOL_SLOTS + 1);
  localparam int IW = $clog2(POOL_SLOTS);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PW-1:0] NULL_PTR = PW'(POOL_SLOTS);

  back_state_e state_q, state_d;

  op_t               op_q, op_d;
  logic [PW-1:0]     slot_q, slot_d;
  logic [PW-1:0]     free_head_q, free_head_d;
  logic [PW-1:0]     fill_q, fill_d;
  logic [PW-1:0]     tops_q [NUM_STACKS];

  // pool memories
  logic signed [DATA_W-1:0] value_mem [POOL_SLOTS];
  logic [PW-1:0]            link_mem  [POOL_SLOTS];
  logic signed [DATA_W-1:0] value_rd_q;
  logic [PW-1:0]            link_rd_q;
  logic [IW-1:0]            rd_addr;
  logic                     mem_we;
  logic                     value_we;
  logic [PW-1:0]            link_wdata;

  // stack top write port
  logic                     tops_we;
  logic [SW-1:0]            tops_widx;
  logic [PW-1:0]            tops_wdata;

  // result register
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_value_q, out_value_d;
  status_e                  out_status_q, out_status_d;
  logic                     out_load;
  logic                     out_free;

  logic [PW-1:0]            top_new;
  logic [PW-1:0]            top_cur;
  logic [PW-1:0]            link_eff;

  assign out_free = !out_valid_q || !out_stall_i;

  // top of the stack named by the queue head, null for an absent stack
  assign top_new = q_op_i.sid_ok ? tops_q[SW'(q_op_i.sid)] : NULL_PTR;
  assign top_cur = tops_q[SW'(op_q.sid)];

  // slots at or above the fill mark were never written and still link upward
  assign link_eff = (slot_q >= fill_q) ? slot_q + PW'(1) : link_rd_q;

  assign rd_addr = slot_d[IW-1:0];

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    slot_d       = slot_q;
    free_head_d  = free_head_q;
    fill_d       = fill_q;
    q_deq_o      = 1'b0;
    mem_we       = 1'b0;
    value_we     = 1'b0;
    link_wdata   = free_head_q;
    tops_we      = 1'b0;
    tops_widx    = SW'(op_q.sid);
    tops_wdata   = slot_q;
    out_load     = 1'b0;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && out_free) begin
          q_deq_o = 1'b1;
          op_d    = q_op_i;
          if (q_op_i.kind == KIND_PUSH) begin
            if (!q_op_i.sid_ok || free_head_q == NULL_PTR) begin
              // pool full or no such stack: dropped at once
              out_load     = 1'b1;
              out_value_d  = '0;
              out_status_d = ST_DROPPED;
            end else begin
              slot_d  = free_head_q;
              state_d = BK_EXEC;
            end
          end else begin
            if (top_new == NULL_PTR) begin
              // empty or absent stack: answered at once
              out_load     = 1'b1;
              out_value_d  = EMPTY_VALUE;
              out_status_d = ST_EMPTY;
            end else begin
              slot_d  = top_new;
              state_d = BK_EXEC;
            end
          end
        end
      end
      BK_EXEC: begin
        mem_we   = 1'b1;
        tops_we  = 1'b1;
        out_load = 1'b1;
        out_status_d = ST_OK;
        if (op_q.kind == KIND_PUSH) begin
          // take the free head, link it above the old top
          free_head_d = link_eff;
          link_wdata  = top_cur;
          value_we    = 1'b1;
          tops_wdata  = slot_q;
          out_value_d = '0;
          if (slot_q == fill_q) begin
            fill_d = fill_q + PW'(1);
          end
        end else begin
          // unlink the top and return it to the free list
          free_head_d = slot_q;
          link_wdata  = free_head_q;
          tops_wdata  = link_eff;
          out_value_d = value_rd_q;
        end
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      free_head_q <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stack tops, all null after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops_q[i] <= NULL_PTR;
      end
    end else if (tops_we) begin
      tops_q[tops_widx] <= tops_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    slot_q       <= slot_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  // link store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[slot_q[IW-1:0]] <= link_wdata;
    end
    link_rd_q <= link_mem[rd_addr];
  end

  // value store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (value_we) begin
      value_mem[slot_q[IW-1:0]] <= op_q.value;
    end
    value_rd_q <= value_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign pop_value_o = out_value_q;
  assign status_o    = out_status_q;

  // checks
  `include "multi_stack_shared_pool_defines.svh"

  `MSP_ASSERT_IMPL(a_exec_out_free, clk_i, rst_ni, state_q == BK_EXEC, !out_valid_q,
                   "result register busy while an item executes")
  `MSP_ASSERT_NEXT(a_exec_gives_result, clk_i, rst_ni, state_q == BK_EXEC, out_valid_q,
                   "executed item gave no result")
  `MSP_ASSERT_IMPL(a_pop_written_slot, clk_i, rst_ni,
                   state_q == BK_EXEC && op_q.kind == KIND_POP, slot_q < fill_q,
                   "pop of a slot never written")
  `MSP_ASSERT_IMPL(a_fill_range, clk_i, rst_ni, 1'b1,
                   fill_q <= NULL_PTR && free_head_q <= NULL_PTR,
                   "fill mark or free head out of range")

endmodule

// ----- rtl/multi_stack_shared_pool.sv -----
// multi-stack shared pool: several lifo stacks drawing slots from one pool.
// Input channel: in_valid_i / in_stall_o with kind_i (0 push, 1 pop), stack_id_i
// and push_value_i. Output channel: out_valid_o / out_stall_i with pop_value_o
// and status_o (0 ok, 1 push dropped, 2 stack empty). Every item gives one result.
// An item enters a two-entry queue, then the back end takes it. A push or pop
// that touches the pool passes through the back end in order: in the idle state
// the slot's link and value are read from the synchronous pool memories, in the
// execute state the free head, stack top and link are updated. A dropped push or
// an empty pop is answered from the idle state. The back end takes no new item
// from the queue while it executes a pool access or while a stalled result waits.
// Reset empties all stacks and makes the whole pool free; no clearing pass is
// needed, untouched slots are tracked by a fill mark.
// When the receiver stalls, the result register holds; the back end stops
// once it holds a result, the queue fills and in_stall_o rises.
// depends on msp_pkg, msp_front and msp_back
module multi_stack_shared_pool #(
  parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS,
  parameter int POOL_SLOTS = msp_pkg::DEF_POOL_SLOTS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [msp_pkg::SID_W-1:0]         stack_id_i,
  input  logic signed [msp_pkg::DATA_W-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [msp_pkg::DATA_W-1:0] pop_value_o,
  output logic [msp_pkg::STATUS_W-1:0]      status_o
);
  import msp_pkg::*;

  logic q_valid;
  logic q_deq;
  op_t  q_op;

  // accept and classify
  msp_front #(
    .NUM_STACKS (NUM_STACKS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .stack_id_i   (stack_id_i),
    .push_value_i (push_value_i),
    .q_valid_o    (q_valid),
    .q_op_o       (q_op),
    .q_deq_i      (q_deq)
  );

  // execute against the pool
  msp_back #(
    .NUM_STACKS (NUM_STACKS),
    .POOL_SLOTS (POOL_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_deq_o     (q_deq),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pop_value_o (pop_value_o),
    .status_o    (status_o)
  );

endmodule
